@@ rtl/core/rrp_pkg.sv @@
// Shared types and constants of the RESP request parser.
// Depends on nothing; imported by every module of the block.
package rrp_pkg;

   // Result kinds
   localparam logic KIND_TOKEN   = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // Verdict codes
   localparam logic [1:0] REPLY_ERROR       = 2'd0;
   localparam logic [1:0] REPLY_PONG        = 2'd1;
   localparam logic [1:0] REPLY_EMPTY_ARRAY = 2'd2;
   localparam logic [1:0] REPLY_NONE        = 2'd3;

   // Protocol characters
   localparam logic [7:0] CHR_STAR   = 8'h2A;
   localparam logic [7:0] CHR_DOLLAR = 8'h24;
   localparam logic [7:0] CHR_CR     = 8'h0D;
   localparam logic [7:0] CHR_LF     = 8'h0A;
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_NINE   = 8'h39;
   localparam logic [7:0] CHR_LOW_A  = 8'h61;
   localparam logic [7:0] CHR_LOW_Z  = 8'h7A;
   localparam logic [7:0] CASE_DIFF  = 8'h20;

   // Result queue geometry
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = 2;
   localparam int LEVEL_W    = 3;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] data_byte;
      logic       end_of_request;
   } rrp_req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  token_byte;
      logic [15:0] token_number;
      logic        token_first;
      logic        token_last;
      logic [1:0]  reply_code;
      logic [15:0] complete_tokens;
      logic        incomplete;
   } rrp_rsp_type;

   // Results produced by one accepted transaction (0, 1 or 2)
   typedef struct packed {
      logic [1:0]  count;
      rrp_rsp_type first;
      rrp_rsp_type second;
   } rrp_pair_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               room;
   } rrp_fifo_status_type;

   function automatic logic [7:0] ping_char(input logic [1:0] pos);
      logic [7:0] c;
      case (pos)
         2'd0:    c = 8'h50; // P
         2'd1:    c = 8'h49; // I
         2'd2:    c = 8'h4E; // N
         default: c = 8'h47; // G
      endcase
      return c;
   endfunction

   function automatic logic [7:0] command_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h43; // C
         3'd1:    c = 8'h4F; // O
         3'd2:    c = 8'h4D; // M
         3'd3:    c = 8'h4D; // M
         3'd4:    c = 8'h41; // A
         3'd5:    c = 8'h4E; // N
         3'd6:    c = 8'h44; // D
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

@@ rtl/core/rrp_parser.sv @@
// Per-byte RESP parse state machine; builds the results of one transaction.
// Depends on rrp_pkg.
module rrp_parser
   import rrp_pkg::*;
#(
   parameter int NUMBER_WIDTH      = 32,
   parameter int TOKEN_COUNT_WIDTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         take,
   input  rrp_req_type  item,
   output rrp_pair_type pair
);

   typedef enum logic [10:0] {
      PH_MARK     = 11'b000_0000_0001,
      PH_COUNT0   = 11'b000_0000_0010,
      PH_COUNT    = 11'b000_0000_0100,
      PH_COUNT_LF = 11'b000_0000_1000,
      PH_DOLLAR   = 11'b000_0001_0000,
      PH_LEN0     = 11'b000_0010_0000,
      PH_LEN      = 11'b000_0100_0000,
      PH_LEN_LF   = 11'b000_1000_0000,
      PH_DATA     = 11'b001_0000_0000,
      PH_SKIP     = 11'b010_0000_0000,
      PH_DONE     = 11'b100_0000_0000
   } rrp_phase_type;

   localparam int NW = NUMBER_WIDTH;
   localparam int TW = TOKEN_COUNT_WIDTH;

   rrp_phase_type   phase_ff, phase_in;
   logic [NW-1:0]   acc_ff, acc_in;
   logic [NW-1:0]   elem_ff, elem_in;
   logic [NW-1:0]   bytes_ff, bytes_in;
   logic [1:0]      skip_ff, skip_in;
   logic [15:0]     cur_ff, cur_in;
   logic [TW-1:0]   total_ff, total_in;
   logic [2:0]      pos_ff, pos_in;
   logic            mping_ff, mping_in;
   logic            mcmd_ff, mcmd_in;
   logic            stop_ff, stop_in;

   logic            tok_emit;
   rrp_rsp_type     tok;
   rrp_rsp_type     verdict;
   logic            verdict_emit;
   logic [15:0]     total_rpt;

   // Decimal digit accumulate: acc*10 + d, flag overflow of NW bits.
   logic [NW+3:0]   acc_ext;
   logic [NW+3:0]   acc_mul;
   logic            is_digit;
   logic            digit_ok;

   assign is_digit = (item.data_byte >= CHR_ZERO) && (item.data_byte <= CHR_NINE);
   assign acc_ext  = {4'b0000, acc_ff};
   assign acc_mul  = (acc_ext << 3) + (acc_ext << 1)
                   + {{NW{1'b0}}, 4'(item.data_byte - CHR_ZERO)};
   assign digit_ok = is_digit && !(|acc_mul[NW+3:NW]);

   always_comb begin
      logic       fin;
      logic [7:0] up;
      logic [NW-1:0] elem_dec;
      logic [NW-1:0] bytes_dec;
      logic [1:0] skip_dec;

      phase_in = phase_ff;
      acc_in   = acc_ff;
      elem_in  = elem_ff;
      bytes_in = bytes_ff;
      skip_in  = skip_ff;
      cur_in   = cur_ff;
      total_in = total_ff;
      pos_in   = pos_ff;
      mping_in = mping_ff;
      mcmd_in  = mcmd_ff;
      stop_in  = stop_ff;
      fin      = 1'b0;
      tok_emit = 1'b0;
      tok      = '0;
      tok.kind = KIND_TOKEN;
      up       = ((item.data_byte >= CHR_LOW_A) && (item.data_byte <= CHR_LOW_Z))
               ? item.data_byte - CASE_DIFF : item.data_byte;
      bytes_dec = bytes_ff - NW'(1);
      skip_dec  = (skip_ff != 2'd0) ? skip_ff - 2'd1 : 2'd0;

      if (take && item.has_byte && !stop_ff) begin
         case (phase_ff)
            PH_MARK: begin
               if (item.data_byte == CHR_STAR) phase_in = PH_COUNT0;
               else stop_in = 1'b1;
            end
            PH_COUNT0, PH_COUNT: begin
               if (item.data_byte == CHR_CR && phase_ff == PH_COUNT) begin
                  phase_in = PH_COUNT_LF;
               end else if (digit_ok) begin
                  acc_in   = acc_mul[NW-1:0];
                  phase_in = PH_COUNT;
               end else begin
                  stop_in = 1'b1;
               end
            end
            PH_COUNT_LF: begin
               if (item.data_byte != CHR_LF) begin
                  stop_in = 1'b1;
               end else begin
                  elem_in  = acc_ff;
                  acc_in   = '0;
                  phase_in = (acc_ff == '0) ? PH_DONE : PH_DOLLAR;
               end
            end
            PH_DOLLAR: begin
               if (item.data_byte == CHR_DOLLAR) begin
                  phase_in = PH_LEN0;
                  acc_in   = '0;
               end else begin
                  stop_in = 1'b1;
               end
            end
            PH_LEN0, PH_LEN: begin
               if (item.data_byte == CHR_CR && phase_ff == PH_LEN) begin
                  phase_in = PH_LEN_LF;
               end else if (digit_ok) begin
                  acc_in   = acc_mul[NW-1:0];
                  phase_in = PH_LEN;
               end else begin
                  stop_in = 1'b1;
               end
            end
            PH_LEN_LF: begin
               if (item.data_byte != CHR_LF) begin
                  stop_in = 1'b1;
               end else begin
                  if (cur_ff == 16'd0) begin
                     mping_in = (acc_ff == NW'(4));
                     mcmd_in  = (acc_ff == NW'(7));
                     pos_in   = 3'd0;
                  end
                  bytes_in = acc_ff;
                  if (acc_ff == '0) fin = 1'b1;
                  else phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               tok_emit         = 1'b1;
               tok.token_byte   = item.data_byte;
               tok.token_number = cur_ff;
               tok.token_first  = (bytes_ff == acc_ff);
               if (cur_ff == 16'd0) begin
                  if (pos_ff[2] || up != ping_char(pos_ff[1:0])) mping_in = 1'b0;
                  if (pos_ff == 3'd7 || up != command_char(pos_ff)) mcmd_in = 1'b0;
                  if (pos_ff != 3'd7) pos_in = pos_ff + 3'd1;
               end
               bytes_in = bytes_dec;
               if (bytes_dec == '0) begin
                  tok.token_last = 1'b1;
                  fin            = 1'b1;
               end
            end
            PH_SKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 2'd0) phase_in = PH_DOLLAR;
            end
            default: begin
            end
         endcase
      end

      // token finished: count it, step to the next element
      elem_dec = (elem_ff != '0) ? elem_ff - NW'(1) : '0;
      if (fin) begin
         if (!(&total_ff)) total_in = total_ff + TW'(1);
         cur_in  = cur_ff + 16'd1;
         elem_in = elem_dec;
         if (elem_dec == '0) begin
            phase_in = PH_DONE;
         end else begin
            phase_in = PH_SKIP;
            skip_in  = 2'd2;
         end
      end
   end

   if (TW > 16) begin : g_sat
      assign total_rpt = (|total_in[TW-1:16]) ? 16'hFFFF : total_in[15:0];
   end else begin : g_ext
      assign total_rpt = 16'(total_in);
   end

   assign verdict_emit = take && item.end_of_request;

   always_comb begin
      verdict                 = '0;
      verdict.kind            = KIND_VERDICT;
      verdict.complete_tokens = total_rpt;
      verdict.incomplete      = stop_in || (phase_in != PH_DONE && phase_in != PH_MARK);
      if (total_in == '0)  verdict.reply_code = REPLY_ERROR;
      else if (mcmd_in)    verdict.reply_code = REPLY_EMPTY_ARRAY;
      else if (mping_in)   verdict.reply_code = REPLY_PONG;
      else                 verdict.reply_code = REPLY_NONE;
   end

   always_comb begin
      pair.second = verdict;
      if (tok_emit && verdict_emit) begin
         pair.count = 2'd2;
         pair.first = tok;
      end else if (tok_emit) begin
         pair.count = 2'd1;
         pair.first = tok;
      end else if (verdict_emit) begin
         pair.count = 2'd1;
         pair.first = verdict;
      end else begin
         pair.count = 2'd0;
         pair.first = tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || verdict_emit) begin
         phase_ff <= PH_MARK;
         acc_ff   <= '0;
         elem_ff  <= '0;
         bytes_ff <= '0;
         skip_ff  <= 2'd0;
         cur_ff   <= 16'd0;
         total_ff <= '0;
         pos_ff   <= 3'd0;
         mping_ff <= 1'b1;
         mcmd_ff  <= 1'b1;
         stop_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         elem_ff  <= elem_in;
         bytes_ff <= bytes_in;
         skip_ff  <= skip_in;
         cur_ff   <= cur_in;
         total_ff <= total_in;
         pos_ff   <= pos_in;
         mping_ff <= mping_in;
         mcmd_ff  <= mcmd_in;
         stop_ff  <= stop_in;
      end
   end

endmodule

@@ rtl/core/rrp_out_fifo.sv @@
// Four-entry result queue taking up to two results per cycle.
// Depends on rrp_pkg.
module rrp_out_fifo
   import rrp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  rrp_pair_type        pair,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output rrp_rsp_type         rsp_item,
   output rrp_fifo_status_type status
);

   rrp_rsp_type        entries_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [PTR_W-1:0]   wr_ptr_nxt;
   logic               pop;

   assign wr_ptr_nxt = wr_ptr_ff + PTR_W'(1);
   assign pop        = rsp_valid && rsp_ready;
   assign wr_ptr_in  = wr_ptr_ff + PTR_W'(pair.count);
   assign rd_ptr_in  = rd_ptr_ff + PTR_W'(pop);
   assign level_in   = level_ff + LEVEL_W'(pair.count) - LEVEL_W'(pop);

   assign rsp_valid     = (level_ff != '0);
   assign rsp_item      = entries_ff[rd_ptr_ff];
   assign status.level  = level_ff;
   assign status.room   = (level_ff <= LEVEL_W'(FIFO_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (pair.count != 2'd0) entries_ff[wr_ptr_ff] <= pair.first;
      if (pair.count == 2'd2) entries_ff[wr_ptr_nxt] <= pair.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

@@ rtl/core/resp_request_parser.sv @@
// Top level of the RESP request parser: parse state machine plus result queue.
// Depends on rrp_pkg, rrp_parser and rrp_out_fifo.
//
// Usage: a request enters one byte per req_ transaction (has_byte set), with
// end_of_request on its last transaction. An empty request is a single
// transaction with has_byte clear and end_of_request set. Each data byte of a
// bulk string comes back as a token result (kind 0) with its token number and
// first/last marks; the end of a request gives one verdict result (kind 1)
// carrying the reply code, the complete-token count and the incomplete flag.
// A transaction yields zero, one or two results.
// Results are registered in the result queue and offered on rsp_ in order.
// Throughput: one request transaction per cycle while req_ready is high; the
// rate is set by the output side, which drains one result per cycle from a
// four-entry queue. req_ready is high while the queue holds two or fewer
// results, so a stalled receiver drops req_ready as soon as three or more
// results are waiting; no result is ever dropped.
// Reset: synchronous; parser returns to waiting for the array marker and the
// queue empties. The parser also returns to that state after every verdict.
module resp_request_parser
   import rrp_pkg::*;
#(
   parameter int NUMBER_WIDTH      = 32,
   parameter int TOKEN_COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  rrp_req_type req_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rrp_rsp_type rsp_item
);

   rrp_pair_type        pair;
   rrp_fifo_status_type fifo_status;
   logic                take;

   // Two free slots are needed: one byte can give a token and a verdict.
   assign req_ready = fifo_status.room;
   assign take      = req_valid && req_ready;

   rrp_parser #(
      .NUMBER_WIDTH      (NUMBER_WIDTH),
      .TOKEN_COUNT_WIDTH (TOKEN_COUNT_WIDTH)
   ) u_parser (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .item  (req_item),
      .pair  (pair)
   );

   rrp_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .pair      (pair),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .status    (fifo_status)
   );

`ifndef NO_ASSERTIONS
   // Queue never overfills.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_status.level <= LEVEL_W'(FIFO_DEPTH))
      else $error("result queue overflow");

   // Results only appear for an accepted transaction.
   a_push_on_take: assert property (@(posedge clock) disable iff (reset)
      pair.count != 2'd0 |-> take)
      else $error("result produced without accepted transaction");

   // A double push is always token first, verdict second.
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      pair.count == 2'd2 |->
         pair.first.kind == KIND_TOKEN && pair.second.kind == KIND_VERDICT)
      else $error("bad result ordering in double push");

   // Accepted transaction with a token and a verdict and no pop raises the level by two.
   a_level_step: assert property (@(posedge clock) disable iff (reset)
      pair.count == 2'd2 && !(rsp_valid && rsp_ready) |=>
         fifo_status.level == $past(fifo_status.level) + LEVEL_W'(2))
      else $error("queue level tracking slip");
`endif

endmodule

@@ sim/tb_resp_request_parser.sv @@
// Testbench for resp_request_parser: byte-stream RESP requests in, token bytes and verdicts out.
// Depends on rrp_pkg and the resp_request_parser RTL; a built-in model predicts every result.
`timescale 1ns / 100ps

module tb_resp_request_parser;
   import rrp_pkg::*;

   localparam int          RANDOM_BYTES = 800;
   localparam int          CYCLE_LIMIT  = 200_000;
   localparam int          IDLE_PCT     = 28;
   localparam logic [63:0] NUMBER_MAX   = 64'hFFFF_FFFF;   // 2^NUMBER_WIDTH - 1
   localparam logic [15:0] TOKENS_MAX   = 16'hFFFF;        // 2^TOKEN_COUNT_WIDTH - 1
   localparam logic [8*4-1:0] PING_TEXT    = "PING";
   localparam logic [8*7-1:0] COMMAND_TEXT = "COMMAND";

   // Parse phases of the model, one per expected protocol element
   typedef enum logic [3:0] {
      ST_MARKER, ST_COUNT_FIRST, ST_COUNT, ST_COUNT_LF, ST_DOLLAR,
      ST_LEN_FIRST, ST_LEN, ST_LEN_LF, ST_DATA, ST_SKIP, ST_DONE
   } parse_phase_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   rrp_req_type req_item;
   logic        rsp_valid;
   logic        rsp_ready;
   rrp_rsp_type rsp_item;

   // Parser model state
   parse_phase_type phase;
   logic [63:0]  number_value;
   logic [63:0]  elements_pending;
   logic [63:0]  data_pending;
   logic [1:0]   skip_count;
   logic [15:0]  token_index;
   logic [15:0]  tokens_done;
   logic [2:0]   first_pos;
   bit           may_be_ping;
   bit           may_be_command;
   bit           parse_halted;

   rrp_rsp_type  token_and_verdict_q[$];   // results still owed by the block
   logic [7:0]   req_bytes[$];             // request under construction

   int           fail_count;
   int           cycle_count;
   int           bytes_fed;
   int           hold_cycles;     // receiver hold-off, counted down by the receiver
   bit           steady_flow;     // no idling on either side while set
   bit           noise_on;        // sprinkle ignored transactions into requests

   resp_request_parser i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Queue appends
   function automatic void owe_result(rrp_rsp_type r);
      token_and_verdict_q.insert(token_and_verdict_q.size(), r);
   endfunction

   function automatic void add_byte(logic [7:0] c);
      req_bytes.insert(req_bytes.size(), c);
   endfunction

   // ---------------------------------------------------------------------
   // Parser model
   // ---------------------------------------------------------------------
   function automatic void clear_parser();
      phase            = ST_MARKER;
      number_value     = '0;
      elements_pending = '0;
      data_pending     = '0;
      skip_count       = '0;
      token_index      = '0;
      tokens_done      = '0;
      first_pos        = '0;
      may_be_ping      = 1'b1;
      may_be_command   = 1'b1;
      parse_halted     = 1'b0;
   endfunction

   // Decimal accumulation; a non-digit or a value past the number width fails
   function automatic bit take_digit(logic [7:0] b);
      logic [63:0] v;
      if (b < CHR_ZERO || b > CHR_NINE) return 1'b0;
      v = number_value * 10 + 64'(b - CHR_ZERO);
      if (v > NUMBER_MAX) return 1'b0;
      number_value = v;
      return 1'b1;
   endfunction

   function automatic void close_token();
      if (tokens_done != TOKENS_MAX) tokens_done++;
      token_index++;                          // wraps at 16 bits
      if (elements_pending > 0) elements_pending--;
      if (elements_pending == 0) begin
         phase = ST_DONE;
      end else begin
         phase      = ST_SKIP;
         skip_count = 2'd2;
      end
   endfunction

   // Advance the model by one accepted transaction and queue what it produces
   function automatic void parse_transaction(rrp_req_type it);
      rrp_rsp_type r;
      logic [7:0]  b;
      logic [7:0]  up;
      b = it.data_byte;
      if (it.has_byte && !parse_halted) begin
         case (phase)
            ST_MARKER: begin
               if (b == CHR_STAR) phase = ST_COUNT_FIRST;
               else parse_halted = 1'b1;
            end
            ST_COUNT_FIRST, ST_COUNT: begin
               if (b == CHR_CR && phase == ST_COUNT) phase = ST_COUNT_LF;
               else if (take_digit(b)) phase = ST_COUNT;
               else parse_halted = 1'b1;
            end
            ST_COUNT_LF: begin
               if (b != CHR_LF) begin
                  parse_halted = 1'b1;
               end else begin
                  elements_pending = number_value;
                  number_value     = '0;
                  phase = (elements_pending == 0) ? ST_DONE : ST_DOLLAR;
               end
            end
            ST_DOLLAR: begin
               if (b == CHR_DOLLAR) begin
                  phase        = ST_LEN_FIRST;
                  number_value = '0;
               end else begin
                  parse_halted = 1'b1;
               end
            end
            ST_LEN_FIRST, ST_LEN: begin
               if (b == CHR_CR && phase == ST_LEN) phase = ST_LEN_LF;
               else if (take_digit(b)) phase = ST_LEN;
               else parse_halted = 1'b1;
            end
            ST_LEN_LF: begin
               if (b != CHR_LF) begin
                  parse_halted = 1'b1;
               end else begin
                  // token 0 (also after wrap) decides the verdict by its length
                  if (token_index == 0) begin
                     may_be_ping    = (number_value == 4);
                     may_be_command = (number_value == 7);
                     first_pos      = '0;
                  end
                  data_pending = number_value;
                  if (data_pending == 0) close_token();
                  else phase = ST_DATA;
               end
            end
            ST_DATA: begin
               r              = '0;
               r.kind         = KIND_TOKEN;
               r.token_byte   = b;
               r.token_number = token_index;
               r.token_first  = (data_pending == number_value);
               if (token_index == 0) begin
                  up = (b >= CHR_LOW_A && b <= CHR_LOW_Z) ? b - CASE_DIFF : b;
                  if (first_pos >= 4 || up != PING_TEXT[8*(3 - int'(first_pos[1:0])) +: 8])
                     may_be_ping = 1'b0;
                  if (first_pos >= 7 || up != COMMAND_TEXT[8*(6 - int'(first_pos)) +: 8])
                     may_be_command = 1'b0;
                  if (first_pos < 7) first_pos++;
               end
               data_pending--;
               if (data_pending == 0) begin
                  r.token_last = 1'b1;
                  close_token();
               end
               owe_result(r);
            end
            ST_SKIP: begin
               // separator after a data field, not checked
               if (skip_count > 0) skip_count--;
               if (skip_count == 0) phase = ST_DOLLAR;
            end
            default: ;
         endcase
      end
      if (it.end_of_request) begin
         r      = '0;
         r.kind = KIND_VERDICT;
         if (tokens_done == 0) r.reply_code = REPLY_ERROR;
         else if (may_be_command) r.reply_code = REPLY_EMPTY_ARRAY;
         else if (may_be_ping) r.reply_code = REPLY_PONG;
         else r.reply_code = REPLY_NONE;
         r.complete_tokens = tokens_done;
         r.incomplete = parse_halted || (phase != ST_DONE && phase != ST_MARKER);
         owe_result(r);
         clear_parser();
      end
   endfunction

   // ---------------------------------------------------------------------
   // Result side: ready pattern and checking
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles--;
      end else if (steady_flow) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      rrp_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (token_and_verdict_q.size() == 0) begin
            $error("result with nothing outstanding: 0x%0h", rsp_item);
            fail_count++;
         end else begin
            want = token_and_verdict_q.pop_front();
            check_field("kind", want.kind, rsp_item.kind);
            check_field("token_byte", want.token_byte, rsp_item.token_byte);
            check_field("token_number", want.token_number, rsp_item.token_number);
            check_field("token_first", want.token_first, rsp_item.token_first);
            check_field("token_last", want.token_last, rsp_item.token_last);
            check_field("reply_code", want.reply_code, rsp_item.reply_code);
            check_field("complete_tokens", want.complete_tokens, rsp_item.complete_tokens);
            check_field("incomplete", want.incomplete, rsp_item.incomplete);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[resp_request_parser] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Called and returns at a falling edge; valid stays up across back-to-back
   // transactions.
   task automatic send_item(input logic has, input logic [7:0] data, input logic eor);
      rrp_req_type it;
      it.has_byte       = has;
      it.data_byte      = data;
      it.end_of_request = eor;
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (!req_ready);
      parse_transaction(it);
      if (has) bytes_fed++;
      @(negedge clock);
   endtask

   // Sends req_bytes as one request; an empty buffer becomes an empty request
   task automatic send_request();
      bit end_alone;
      int i;
      end_alone = noise_on && req_bytes.size() > 0 && $urandom_range(19) == 0;
      if (req_bytes.size() == 0) begin
         send_item(1'b0, 8'($urandom_range(255)), 1'b1);
      end
      for (i = 0; i < req_bytes.size(); i++) begin
         if (noise_on && $urandom_range(29) == 0)
            send_item(1'b0, 8'($urandom_range(255)), 1'b0);
         send_item(1'b1, req_bytes[i], !end_alone && i == req_bytes.size() - 1);
      end
      if (end_alone) send_item(1'b0, 8'($urandom_range(255)), 1'b1);
      req_bytes.delete();
   endtask

   // Sender goes quiet until every owed result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (token_and_verdict_q.size() != 0);
   endtask

   task automatic put_text(input string s, input bit vary_case);
      logic [7:0] c;
      int i;
      for (i = 0; i < s.len(); i++) begin
         c = s[i];
         if (vary_case && c >= "A" && c <= "Z" && $urandom_range(1)) c = c + CASE_DIFF;
         add_byte(c);
      end
   endtask

   task automatic put_number(input longint unsigned value, input int zeros);
      repeat (zeros) add_byte(CHR_ZERO);
      put_text($sformatf("%0d", value), 1'b0);
   endtask

   task automatic put_crlf();
      add_byte(CHR_CR);
      add_byte(CHR_LF);
   endtask

   function automatic int some_zeros();
      return ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0;
   endfunction

   // One bulk string: first token leans toward the verdict words
   task automatic put_bulk(input bit first_token);
      int pick;
      int len;
      int i;
      string word;
      pick = first_token ? $urandom_range(9) : 9;
      if (pick == 3 || pick == 4 || (pick == 5 && $urandom_range(1))) word = "COMMAND";
      else word = "PING";
      add_byte(CHR_DOLLAR);
      if (pick <= 5) begin
         put_number(word.len(), some_zeros());
         put_crlf();
         put_text(word, 1'b1);
         // near miss: one letter replaced
         if (pick == 5)
            req_bytes[req_bytes.size() - 1 - $urandom_range(word.len() - 1)] =
               8'($urandom_range(255));
      end else begin
         len = ($urandom_range(19) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
         put_number(len, some_zeros());
         put_crlf();
         for (i = 0; i < len; i++) add_byte(8'($urandom_range(255)));
      end
      if ($urandom_range(9) == 0) begin
         add_byte(8'($urandom_range(255)));
         add_byte(8'($urandom_range(255)));
      end else begin
         put_crlf();
      end
   endtask

   function automatic longint unsigned edge_number();
      case ($urandom_range(3))
         0:       return 64'd4294967295;
         1:       return 64'd4294967296;
         2:       return 64'd42949672950;
         default: return 64'($urandom);
      endcase
   endfunction

   task automatic build_random_request();
      int style;
      int n;
      int declared;
      int i;
      style = $urandom_range(99);
      if (style < 5) begin
         // garbage, sometimes behind a valid marker
         if ($urandom_range(1)) add_byte(CHR_STAR);
         repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(255)));
         return;
      end
      if (style < 9) begin
         // counts and lengths at and past the number width
         add_byte(CHR_STAR);
         put_number($urandom_range(1) ? edge_number() : $urandom_range(1, 3), 0);
         put_crlf();
         add_byte(CHR_DOLLAR);
         put_number($urandom_range(1) ? edge_number() : $urandom_range(0, 3), 0);
         put_crlf();
         put_text("ping", 1'b1);
         return;
      end
      if (style < 11) return;   // empty request
      n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
      declared = ($urandom_range(9) == 0) ? n + $urandom_range(1, 3) : n;
      add_byte(CHR_STAR);
      put_number(declared, some_zeros());
      put_crlf();
      for (i = 0; i < n; i++) put_bulk(i == 0);
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(255)));
      if (style < 26 && req_bytes.size() > 0) begin
         // cut short anywhere, including down to nothing
         n = $urandom_range(req_bytes.size() - 1);
         while (req_bytes.size() > n) void'(req_bytes.pop_back());
      end else if (style < 36) begin
         req_bytes[$urandom_range(req_bytes.size() - 1)] = 8'($urandom_range(255));
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_directed();
      send_request();                          // empty request
      put_text("X", 1'b0);                     // no array marker
      send_request();
      put_text("*0", 1'b0); put_crlf();        // zero count
      send_request();
      send_item(1'b0, 8'hFF, 1'b0);            // ignored transaction
      put_text("*1", 1'b0); put_crlf();        // ping in mixed case
      put_text("$4", 1'b0); put_crlf();
      put_text("pInG", 1'b0);
      send_request();
      put_text("*1", 1'b0); put_crlf();        // zero-length token only
      put_text("$0", 1'b0); put_crlf();
      send_request();
      wait_drained();
   endtask

   // Receiver holds off while a long token streams in: queue fills, req_ready drops
   task automatic test_backpressure();
      int i;
      hold_cycles = 150;
      put_text("*1", 1'b0); put_crlf();
      put_text("$40", 1'b0); put_crlf();
      for (i = 0; i < 40; i++) add_byte(8'($urandom_range(255)));
      send_request();
      wait_drained();
   endtask

   // Both sides run flat out for a stretch of random requests
   task automatic test_steady_stream();
      int i;
      steady_flow = 1'b1;
      for (i = 0; i < 12; i++) begin
         build_random_request();
         send_request();
      end
      wait_drained();
      steady_flow = 1'b0;
   endtask

   task automatic test_random();
      int target;
      target   = bytes_fed + RANDOM_BYTES;
      noise_on = 1'b1;
      while (bytes_fed < target) begin
         build_random_request();
         send_request();
      end
      noise_on = 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_item    = '0;
      bytes_fed   = 0;
      hold_cycles = 0;
      steady_flow = 1'b0;
      noise_on    = 1'b0;
      clear_parser();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_backpressure();
      test_steady_stream();
      test_random();

      wait_drained();
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("[resp_request_parser] OK");
      end else begin
         $display("[resp_request_parser] ERROR");
      end
      $finish;
   end

endmodule
